// ===== rtl/cmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants, types and state codes of the CMWC4096 word generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

  localparam int unsigned LAG_DEPTH_DEF = 4096;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned CARRY_W       = 19;
  localparam int unsigned MUL_W         = 15;
  localparam int unsigned PROD_W        = WORD_W + MUL_W + 1;

  localparam logic [WORD_W-1:0]  CMWC_PHI    = 32'h9e37_79b9;
  localparam logic [MUL_W-1:0]   CMWC_MUL    = 15'd18782;
  localparam logic [WORD_W-1:0]  CMWC_R      = 32'hffff_fffe;
  localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_FIN
  } cmwc_state_t;

  // Result of the finishing step of one draw
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [CARRY_W-1:0] carry;
  } cmwc_draw_res_t;

endpackage

// ===== rtl/cmwc_if.sv =====
// ----------------------------------------------------------------------------
// cmwc_in_if / cmwc_out_if
// Valid/ready channels of the generator: request items in, words out.
// ----------------------------------------------------------------------------
interface cmwc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [cmwc_pkg::WORD_W-1:0] seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

interface cmwc_out_if;
  logic                       valid;
  logic                       ready;
  logic [cmwc_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/cmwc_lag_mem.sv =====
// ----------------------------------------------------------------------------
// cmwc_lag_mem
// Lag table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cmwc_lag_mem #(
  parameter int unsigned DEPTH = cmwc_pkg::LAG_DEPTH_DEF,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [cmwc_pkg::WORD_W-1:0] wr_data,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [cmwc_pkg::WORD_W-1:0] rd_data
);
  import cmwc_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cmwc_draw_dp.sv =====
// ----------------------------------------------------------------------------
// cmwc_draw_dp
// Draw arithmetic: registered multiply-add, then carry split and correction.
// ----------------------------------------------------------------------------
module cmwc_draw_dp (
  input  logic                         clk,
  input  logic                         mul_en,
  input  logic [cmwc_pkg::WORD_W-1:0]  lag_word,
  input  logic [cmwc_pkg::CARRY_W-1:0] carry_in,
  output cmwc_pkg::cmwc_draw_res_t     res
);
  import cmwc_pkg::*;

  localparam int unsigned HI_W = PROD_W - WORD_W;

  logic [PROD_W-1:0] t_r;
  logic [PROD_W-1:0] t_nxt;
  logic [HI_W-1:0]   c_hi;
  logic [WORD_W:0]   sum;
  logic [WORD_W-1:0] x;
  logic              wrap;
  logic [HI_W:0]     c_inc;

  // 18782 * q + carry, held for the finishing cycle
  always_comb begin
    t_nxt = PROD_W'(lag_word) * PROD_W'(CMWC_MUL) + PROD_W'(carry_in);
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      t_r <= t_nxt;
    end
  end

  always_comb begin
    c_hi  = t_r[PROD_W-1:WORD_W];
    sum   = {1'b0, t_r[WORD_W-1:0]} + (WORD_W+1)'(c_hi);
    x     = sum[WORD_W-1:0];
    wrap  = x < WORD_W'(c_hi);
    c_inc = {1'b0, c_hi} + (HI_W+1)'(1);
    // bump x and carry when the sum wrapped below the carry
    res.word  = wrap ? (CMWC_R - x - WORD_W'(1)) : (CMWC_R - x);
    res.carry = wrap ? CARRY_W'(c_inc) : CARRY_W'(c_hi);
  end

endmodule

// ===== rtl/cmwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmwc_ctrl
// Sequencer: seed sweep over the table, draw steps, index, carry and output.
// ----------------------------------------------------------------------------
module cmwc_ctrl #(
  parameter int unsigned LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF,
  parameter int unsigned IDX_W     = $clog2(LAG_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cmwc_in_if.sink                      in_chan,
  cmwc_out_if.source                   out_chan,
  output logic                         mem_wr_en,
  output logic [IDX_W-1:0]             mem_wr_addr,
  output logic [cmwc_pkg::WORD_W-1:0]  mem_wr_data,
  output logic [IDX_W-1:0]             mem_rd_addr,
  output logic                         mul_en,
  output logic [cmwc_pkg::CARRY_W-1:0] carry,
  input  cmwc_pkg::cmwc_draw_res_t     draw_res
);
  import cmwc_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LAG_DEPTH - 1);

  cmwc_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt, idx_adv;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0]  base_r, base_nxt;
  logic [WORD_W-1:0]  e3_r, e2_r, e1_r;
  logic [WORD_W-1:0]  seed_word;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r;
  logic               in_fire, fin_go, seed_done;

  assign idx_adv   = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign fin_go    = !out_valid_r || out_chan.ready;
  assign seed_done = (cnt_r == IDX_LAST);

  // first three entries step by the constant, the rest mix earlier entries
  always_comb begin
    if (cnt_r < IDX_W'(3)) begin
      seed_word = base_r;
    end else begin
      seed_word = e3_r ^ e2_r ^ CMWC_PHI ^ WORD_W'(cnt_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_chan.kind == KIND_SEED) ? ST_SEED : ST_MUL;
        end
      end
      ST_SEED: begin
        if (seed_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    in_chan.ready = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r;
    mem_wr_data   = draw_res.word;
    mem_rd_addr   = idx_adv;
    mul_en        = 1'b0;
    idx_nxt       = idx_r;
    carry_nxt     = carry_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_fire) begin
          if (in_chan.kind == KIND_SEED) begin
            cnt_nxt  = '0;
            base_nxt = in_chan.seed_value;
          end else begin
            idx_nxt = idx_adv;
          end
        end
      end
      ST_SEED: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cnt_r;
        mem_wr_data = seed_word;
        cnt_nxt     = cnt_r + IDX_W'(1);
        base_nxt    = base_r + CMWC_PHI;
      end
      ST_MUL: begin
        mul_en = 1'b1;
      end
      ST_FIN: begin
        if (fin_go) begin
          mem_wr_en     = 1'b1;
          carry_nxt     = draw_res.carry;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= IDX_LAST;
      carry_r     <= CARRY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      carry_r     <= carry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    base_r <= base_nxt;
    if (state_r == ST_SEED) begin
      e3_r <= e2_r;
      e2_r <= e1_r;
      e1_r <= seed_word;
    end
    if (state_r == ST_FIN && fin_go) begin
      out_word_r <= draw_res.word;
    end
  end

  assign carry                = carry_r;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.random_word = out_word_r;

endmodule

// ===== rtl/cmwc_random_word_generator.sv =====
// ----------------------------------------------------------------------------
// cmwc_random_word_generator
// CMWC4096 complementary multiply-with-carry generator around one lag table.
// ----------------------------------------------------------------------------
// Draw: the table read is issued on the accepting edge, then multiply, then
//   finish and write back, which registers the result; a new draw is only
//   taken once the last one has finished, and finish stalls on a full output.
// Seed: walks the whole table, one table entry written per cycle; no result.
// Reset (synchronous, active low): carry 362436, index LAG_DEPTH-1, output
//   empty; the lag table is not cleared and holds nothing until seeded.
module cmwc_random_word_generator #(
  parameter int unsigned LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cmwc_in_if.sink    in_chan,
  cmwc_out_if.source out_chan
);
  import cmwc_pkg::*;

  localparam int unsigned IDX_W = $clog2(LAG_DEPTH);

  // table port signals
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [WORD_W-1:0]  mem_wr_data;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic [WORD_W-1:0]  mem_rd_data;

  // draw datapath hookup
  logic               mul_en;
  logic [CARRY_W-1:0] carry;
  cmwc_draw_res_t     draw_res;

  // Sequencer: accepts an item only when idle, walks the table on a seed,
  // steps a draw through read, multiply and finish. The read is issued on
  // the accepting edge at the advanced index, so data is there for multiply.
  cmwc_ctrl #(
    .LAG_DEPTH (LAG_DEPTH),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mul_en      (mul_en),
    .carry       (carry),
    .draw_res    (draw_res)
  );

  // Lag table. Successive draws touch different entries, and the write of
  // one draw lands before the read of the next, so no forwarding is needed.
  cmwc_lag_mem #(
    .DEPTH (LAG_DEPTH),
    .IDX_W (IDX_W)
  ) u_lag_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Multiply-with-carry arithmetic: one registered multiply-add, then the
  // carry split, overflow correction and complement in the finishing cycle.
  cmwc_draw_dp u_draw_dp (
    .clk      (clk),
    .mul_en   (mul_en),
    .lag_word (mem_rd_data),
    .carry_in (carry),
    .res      (draw_res)
  );

endmodule

// ===== sim/cmwc_word_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cmwc_word_checker
// Watches both channels of the CMWC4096 generator. Keeps its own lag table,
// carry and index, predicts each drawn word and compares it with the words
// that leave the block. Hands the failure count back to the testbench top.
// ----------------------------------------------------------------------------
module cmwc_word_checker #(
  parameter int unsigned LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cmwc_in_if          in_mon,
  cmwc_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned outstanding,
  output int unsigned words_checked
);
  import cmwc_pkg::*;

  logic [WORD_W-1:0]  lag_words [LAG_DEPTH];
  logic [CARRY_W-1:0] carry_state;
  int unsigned        index_state;
  logic [WORD_W-1:0]  expected_words [$];
  int unsigned        fails;
  int unsigned        checked;

  assign fail_count    = fails;
  assign words_checked = checked;

  // Rebuild the whole lag table from one seed word; carry and index stay
  function automatic void fill_table(input logic [WORD_W-1:0] seed);
    lag_words[0] = seed;
    lag_words[1] = seed + CMWC_PHI;
    lag_words[2] = seed + CMWC_PHI + CMWC_PHI;
    for (int unsigned i = 3; i < LAG_DEPTH; i++)
      lag_words[i] = lag_words[i-3] ^ lag_words[i-2] ^ CMWC_PHI ^ WORD_W'(i);
  endfunction

  // Advance the index, run one multiply-with-carry step and write back
  function automatic logic [WORD_W-1:0] next_word();
    logic [63:0]       prod;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    index_state = (index_state + 1) % LAG_DEPTH;
    prod = 64'(CMWC_MUL) * 64'(lag_words[index_state]) + 64'(carry_state);
    hi   = prod[63:32];
    lo   = prod[31:0] + hi;
    if (lo < hi) begin
      lo = lo + 1'b1;
      hi = hi + 1'b1;
    end
    carry_state = hi[CARRY_W-1:0];
    lo = CMWC_R - lo;
    lag_words[index_state] = lo;
    return lo;
  endfunction

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      carry_state = CARRY_RESET;
      index_state = LAG_DEPTH - 1;
      expected_words.delete();
      outstanding <= 0;
    end else begin
      // compare the leaving word first: it always belongs to an earlier draw
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_words.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t chk: word %h arrived with no draw waiting", $time,
                     out_mon.random_word);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (out_mon.random_word !== want) begin
            fails++;
            if (fails <= 10)
              $display("%t chk: random_word expected %h got %h", $time, want,
                       out_mon.random_word);
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.kind == KIND_SEED)
          fill_table(in_mon.seed_value);
        else
          expected_words.push_back(next_word());
      end
      outstanding <= expected_words.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the CMWC4096 word generator. Reseeds and draws go
// in with random gaps while the output side stalls at random; the checker
// beside the block predicts every word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import cmwc_pkg::*;

  localparam int unsigned LAG         = LAG_DEPTH_DEF;
  localparam int unsigned ITEM_TARGET = 1600;
  localparam int unsigned HOLD_CYCLES = 400;
  // Every reseed walks the whole table; a few dozen of them plus all draws at
  // their slowest stay well below this.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned words_checked;
  int unsigned cycle_count;
  int unsigned seeds_sent;
  int unsigned draws_sent;
  bit          calm;       // no idling on either side while set
  bit          hold_req;   // ask the receiver for one long hold-off

  cmwc_in_if  in_chan ();
  cmwc_out_if out_chan ();

  cmwc_random_word_generator #(
    .LAG_DEPTH (LAG)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cmwc_word_checker #(
    .LAG_DEPTH (LAG)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Gap length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  // With no gap, valid simply stays high into the next item.
  task automatic send_item(input logic kind_v, input logic [WORD_W-1:0] seed_v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= kind_v;
    in_chan.seed_value <= seed_v;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (kind_v == KIND_SEED) seeds_sent++;
    else draws_sent++;
  endtask

  // Wait until every drawn word has left the block. Step an edge first so
  // that the checker has booked an item accepted at the current edge.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Receiver: random stalls of random length, plus one long hold-off on
  // request so the block backs up and stalls its input.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        out_chan.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_req <= 1'b0;
      end else if (stall_left != 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm && $urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timed out, %0d words still outstanding", outstanding);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [WORD_W-1:0] seed_pick;
    cycle_count = 0;
    seeds_sent  = 0;
    draws_sent  = 0;
    calm        = 1'b0;
    hold_req    <= 1'b0;
    rst_n       <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= KIND_SEED;
    in_chan.seed_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The table is undefined until seeded, so seed first.
    // The first draw wraps the index from the top entry to entry zero and
    // uses the large reset carry.
    send_item(KIND_SEED, 32'h0000_0000);
    repeat (3) send_item(KIND_DRAW, $urandom());
    // extreme seeds; draws carry extreme (ignored) seed fields too
    send_item(KIND_SEED, 32'hffff_ffff);
    send_item(KIND_DRAW, 32'hffff_ffff);
    send_item(KIND_DRAW, 32'h0000_0000);
    send_item(KIND_SEED, 32'haaaa_aaaa);
    send_item(KIND_DRAW, 32'h5555_5555);
    send_item(KIND_SEED, 32'h5555_5555);
    send_item(KIND_DRAW, 32'haaaa_aaaa);
    // seed that wraps the second entry to zero
    send_item(KIND_SEED, 32'h0 - CMWC_PHI);
    repeat (2) send_item(KIND_DRAW, $urandom());
    // reseed straight after a reseed, carry and index carry on
    send_item(KIND_SEED, $urandom());
    send_item(KIND_SEED, $urandom());
    send_item(KIND_DRAW, $urandom());

    // Random part: mostly draws, now and then a reseed. Every so often drop
    // all idling for a stretch.
    for (int unsigned n = 0; n < ITEM_TARGET; n++) begin
      if (n % 200 == 150) calm = 1'b1;
      else if (n % 200 == 190) calm = 1'b0;
      // long output hold-off while the sender keeps offering draws
      if (n == 400) hold_req <= 1'b1;
      // pause the sender until every word has come out
      if (n == 900) begin
        in_chan.valid <= 1'b0;
        wait_drained();
      end
      if ($urandom_range(99) < 2) begin
        case ($urandom_range(3))
          0:       seed_pick = 32'h0000_0000;
          1:       seed_pick = 32'hffff_ffff;
          default: seed_pick = $urandom();
        endcase
        send_item(KIND_SEED, seed_pick);
      end else begin
        send_item(KIND_DRAW, $urandom());
      end
    end
    in_chan.valid <= 1'b0;

    // Drain, then allow for a reseed that may still be walking the table
    wait_drained();
    repeat (LAG + 16) @(posedge clk);

    $display("tb: %0d reseeds and %0d draws sent, %0d words compared", seeds_sent,
             draws_sent, words_checked);
    $display("tb: random gaps on both sides, one long output hold-off, one drain pause");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cmwc_pkg.sv
rtl/cmwc_if.sv
rtl/cmwc_lag_mem.sv
rtl/cmwc_draw_dp.sv
rtl/cmwc_ctrl.sv
rtl/cmwc_random_word_generator.sv
sim/cmwc_word_checker.sv
sim/tb_top.sv
